// ----- rtl/fbsa_pkg.sv -----
`timescale 1ns / 1ps

package fbsa_pkg;

   // fixed field widths of the ports
   localparam int REQ_W      = 2;
   localparam int BNO_W      = 24;
   localparam int IDX_W      = 6;
   localparam int VAL_W      = 24;
   localparam int STAT_W     = 3;
   localparam int START_W    = 16;
   localparam int TOTAL_W    = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BLOCKS = 1'd1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK            = 3'd0,
      ST_NO_SPACE      = 3'd1,
      ST_BAD_BLOCK     = 3'd2,
      ST_FREE_IGNORED  = 3'd3,
      ST_COUNT_CLAMPED = 3'd4
   } status_type;

   // which result the datapath builds
   typedef enum logic [2:0] {
      SEL_NO_SPACE,
      SEL_FREE_IGNORED,
      SEL_OK,
      SEL_LOAD,
      SEL_ALLOC,
      SEL_DUMP_COUNT,
      SEL_DUMP_ENTRY
   } rsp_sel_type;

   typedef struct packed {
      logic        capture;
      logic        rd_top;
      logic        wr_sentinel;
      logic        push;
      logic        load_apply;
      logic        flush_start;
      logic        flush_next;
      logic        flush_finish;
      logic        emit;
      rsp_sel_type sel;
   } fbsa_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_kind;
      logic             count_zero;
      logic             count_full;
      logic             free_ok;
      logic             out_free;
      logic             flush_last;
   } fbsa_stat_type;

endpackage

// ----- rtl/free_block_stack_allocator_top.sv -----
`timescale 1ns / 1ps
// accept to response valid with the output register free: load, rejected free, empty
//    alloc and unknown request are answered from the exec state; alloc (cache ram read
//    of the stack top) via the alloc response state, plain free via the free push state
// free into a full cache: count word from the flush count state, then one flush word per
//    cycle while the output register is free, paced by the cache ram's single read port
// sync active-high reset clears count, fsm, result valid, resets config; ram undefined

module free_block_stack_allocator_top #(
   parameter int CACHE_ENTRIES = 50,
   parameter int BLOCK_BITS    = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fbsa_pkg::REQ_W-1:0]      req_type,
   input  logic [fbsa_pkg::BNO_W-1:0]      req_block_number,
   input  logic [fbsa_pkg::IDX_W-1:0]      req_load_index,
   input  logic [fbsa_pkg::VAL_W-1:0]      req_load_value,
   // configuration writes
   input  logic                            csr_write_enable,
   input  logic [fbsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbsa_pkg::CSR_DATA_W-1:0] csr_write_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fbsa_pkg::STAT_W-1:0]     rsp_status,
   output logic [fbsa_pkg::BNO_W-1:0]      rsp_granted_block,
   output logic                            rsp_reload_needed,
   output logic                            rsp_dump_valid,
   output logic [fbsa_pkg::IDX_W-1:0]      rsp_dump_index,
   output logic [fbsa_pkg::VAL_W-1:0]      rsp_dump_value,
   output logic                            rsp_last
);

   import fbsa_pkg::*;

   // command and status between fsm and datapath
   fbsa_cmd_type  cmd;
   fbsa_stat_type stat;

   // fsm: one request transaction at a time, sequences ram reads and writes
   // and decides when a response transaction is loaded into the output register
   fbsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: config registers, stack count, cache ram, range checks,
   // response register (holds a result while the fsm moves on)
   fbsa_dp #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .BLOCK_BITS    (BLOCK_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_block_number  (req_block_number),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_block (rsp_granted_block),
      .rsp_reload_needed (rsp_reload_needed),
      .rsp_dump_valid    (rsp_dump_valid),
      .rsp_dump_index    (rsp_dump_index),
      .rsp_dump_value    (rsp_dump_value),
      .rsp_last          (rsp_last)
   );

   // a new result is only loaded when the output register is free
   a_emit_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("response loaded over a pending response");

   // at most one cache write or count update source per cycle
   a_one_update : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rd_top, cmd.wr_sentinel, cmd.push, cmd.load_apply, cmd.flush_finish}))
      else $error("conflicting cache updates");

   // an accepted request makes the block busy in the next cycle
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in work");

   // flush words and reload flags never mix, and reload comes with a granted block
   a_dump_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reload_needed) |->
         (!rsp_dump_valid && (rsp_status == ST_OK || rsp_status == ST_BAD_BLOCK)))
      else $error("reload flag on a response that is not a grant");

endmodule

// ----- rtl/fbsa_ram.sv -----
`timescale 1ns / 1ps

module fbsa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 50
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fbsa_ctrl.sv -----
`timescale 1ns / 1ps

module fbsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fbsa_pkg::fbsa_stat_type stat,
   output fbsa_pkg::fbsa_cmd_type  cmd
);

   import fbsa_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE        = 6'b000001,
      S_EXEC        = 6'b000010,
      S_ALLOC_RESP  = 6'b000100,
      S_FREE_PUSH   = 6'b001000,
      S_FLUSH_COUNT = 6'b010000,
      S_FLUSH_ENTRY = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = SEL_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.req_kind)
               REQ_ALLOC: begin
                  if (stat.count_zero) begin
                     cmd.sel = SEL_NO_SPACE;
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else begin
                     cmd.rd_top = 1'b1;
                     state_in   = S_ALLOC_RESP;
                  end
               end
               REQ_FREE: begin
                  if (!stat.free_ok) begin
                     cmd.sel = SEL_FREE_IGNORED;
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else if (stat.count_zero) begin
                     cmd.wr_sentinel = 1'b1;
                     state_in        = S_FREE_PUSH;
                  end else if (stat.count_full) begin
                     state_in = S_FLUSH_COUNT;
                  end else begin
                     state_in = S_FREE_PUSH;
                  end
               end
               REQ_LOAD: begin
                  cmd.sel = SEL_LOAD;
                  if (stat.out_free) begin
                     cmd.load_apply = 1'b1;
                     cmd.emit       = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               default: begin
                  // unknown request: one plain ok result
                  cmd.sel = SEL_OK;
                  if (stat.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_ALLOC_RESP: begin
            cmd.sel = SEL_ALLOC;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FREE_PUSH: begin
            cmd.sel = SEL_OK;
            if (stat.out_free) begin
               cmd.push = 1'b1;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FLUSH_COUNT: begin
            cmd.sel = SEL_DUMP_COUNT;
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.flush_start = 1'b1;
               state_in        = S_FLUSH_ENTRY;
            end
         end
         S_FLUSH_ENTRY: begin
            cmd.sel = SEL_DUMP_ENTRY;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.flush_last) begin
                  cmd.flush_finish = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  cmd.flush_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- rtl/fbsa_dp.sv -----
`timescale 1ns / 1ps

module fbsa_dp #(
   parameter int CACHE_ENTRIES = 50,
   parameter int BLOCK_BITS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbsa_pkg::fbsa_cmd_type              cmd,
   output fbsa_pkg::fbsa_stat_type             stat,
   input  logic [fbsa_pkg::REQ_W-1:0]          req_type,
   input  logic [fbsa_pkg::BNO_W-1:0]          req_block_number,
   input  logic [fbsa_pkg::IDX_W-1:0]          req_load_index,
   input  logic [fbsa_pkg::VAL_W-1:0]          req_load_value,
   input  logic                                csr_write_enable,
   input  logic [fbsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbsa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fbsa_pkg::STAT_W-1:0]         rsp_status,
   output logic [fbsa_pkg::BNO_W-1:0]          rsp_granted_block,
   output logic                                rsp_reload_needed,
   output logic                                rsp_dump_valid,
   output logic [fbsa_pkg::IDX_W-1:0]          rsp_dump_index,
   output logic [fbsa_pkg::VAL_W-1:0]          rsp_dump_value,
   output logic                                rsp_last
);

   import fbsa_pkg::*;

   localparam int ADDR_W  = $clog2(CACHE_ENTRIES);
   localparam int COUNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam int CMP_W   = (BLOCK_BITS > BNO_W) ? BLOCK_BITS : BNO_W;

   // configuration
   logic [START_W-1:0] data_start_ff;
   logic [TOTAL_W-1:0] total_blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff   <= START_W'(2);
         total_blocks_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DATA_START:   data_start_ff   <= csr_write_data[START_W-1:0];
            CSR_TOTAL_BLOCKS: total_blocks_ff <= csr_write_data[TOTAL_W-1:0];
            default:          ;
         endcase
      end
   end

   // latched request
   logic [REQ_W-1:0] req_type_ff;
   logic [BNO_W-1:0] bno_ff;
   logic [IDX_W-1:0] lidx_ff;
   logic [VAL_W-1:0] lval_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         bno_ff      <= req_block_number;
         lidx_ff     <= req_load_index;
         lval_ff     <= req_load_value;
      end
   end

   // stack count and flush pointer
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [COUNT_W-1:0] count_m1;
   logic [IDX_W-1:0]   lidx_m1;
   logic               lval_clamp;
   logic               load_entry;

   assign count_m1   = count_ff - COUNT_W'(1);
   assign lidx_m1    = lidx_ff - IDX_W'(1);
   assign lval_clamp = (lval_ff > VAL_W'(CACHE_ENTRIES));
   assign load_entry = (lidx_ff != '0) && (lidx_ff <= IDX_W'(CACHE_ENTRIES));

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.rd_top) begin
         count_in = count_m1;
      end
      if (cmd.wr_sentinel || cmd.flush_finish) begin
         count_in = COUNT_W'(1);
      end
      if (cmd.push) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.load_apply && (lidx_ff == '0)) begin
         count_in = lval_clamp ? COUNT_W'(CACHE_ENTRIES) : lval_ff[COUNT_W-1:0];
      end
      if (cmd.flush_start) begin
         ptr_in = '0;
      end
      if (cmd.flush_next) begin
         ptr_in = ptr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      ptr_ff <= ptr_in;
   end

   // block values kept at BLOCK_BITS
   logic [CMP_W-1:0]      bno_ext;
   logic [CMP_W-1:0]      lval_ext;
   logic [BLOCK_BITS-1:0] bno_blk;
   logic [BLOCK_BITS-1:0] lval_blk;

   assign bno_ext  = CMP_W'(bno_ff);
   assign lval_ext = CMP_W'(lval_ff);
   assign bno_blk  = bno_ext[BLOCK_BITS-1:0];
   assign lval_blk = lval_ext[BLOCK_BITS-1:0];

   // cache memory
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [BLOCK_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [BLOCK_BITS-1:0] ram_rd_data;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      if (cmd.wr_sentinel) begin
         ram_wr_en = 1'b1;
      end else if (cmd.push) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = count_ff[ADDR_W-1:0];
         ram_wr_data = bno_blk;
      end else if (cmd.flush_finish) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = bno_blk;
      end else if (cmd.load_apply && load_entry) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = lidx_m1[ADDR_W-1:0];
         ram_wr_data = lval_blk;
      end
   end

   always_comb begin
      ram_rd_en   = cmd.rd_top || cmd.flush_start || cmd.flush_next;
      ram_rd_addr = '0;
      if (cmd.rd_top) begin
         ram_rd_addr = count_m1[ADDR_W-1:0];
      end else if (cmd.flush_next) begin
         ram_rd_addr = ptr_ff + ADDR_W'(1);
      end
   end

   fbsa_ram #(
      .WIDTH (BLOCK_BITS),
      .DEPTH (CACHE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // range checks
   logic [CMP_W-1:0] rd_ext;
   logic [CMP_W-1:0] start_ext;
   logic [CMP_W-1:0] total_ext;
   logic [CMP_W-1:0] bno_blk_ext;
   logic             free_in_range;
   logic             pop_in_range;

   assign rd_ext        = CMP_W'(ram_rd_data);
   assign start_ext     = CMP_W'(data_start_ff);
   assign total_ext     = CMP_W'(total_blocks_ff);
   assign bno_blk_ext   = CMP_W'(bno_blk);
   assign free_in_range = (bno_blk_ext >= start_ext) && (bno_blk_ext < total_ext);
   assign pop_in_range  = (rd_ext >= start_ext) && (rd_ext < total_ext);

   // result register
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [BNO_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic               rsp_reload_ff, rsp_reload_in;
   logic               rsp_dump_valid_ff, rsp_dump_valid_in;
   logic [IDX_W-1:0]   rsp_dump_index_ff, rsp_dump_index_in;
   logic [VAL_W-1:0]   rsp_dump_value_ff, rsp_dump_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_status_in     = ST_OK;
      rsp_granted_in    = '0;
      rsp_reload_in     = 1'b0;
      rsp_dump_valid_in = 1'b0;
      rsp_dump_index_in = '0;
      rsp_dump_value_in = '0;
      rsp_last_in       = 1'b1;
      case (cmd.sel)
         SEL_NO_SPACE:     rsp_status_in = ST_NO_SPACE;
         SEL_FREE_IGNORED: rsp_status_in = ST_FREE_IGNORED;
         SEL_OK:           rsp_status_in = ST_OK;
         SEL_LOAD: begin
            if ((lidx_ff == '0) && lval_clamp) begin
               rsp_status_in = ST_COUNT_CLAMPED;
            end
         end
         SEL_ALLOC: begin
            // zero sentinel means the chain has ended
            if (ram_rd_data == '0) begin
               rsp_status_in = ST_NO_SPACE;
            end else begin
               rsp_status_in  = pop_in_range ? ST_OK : ST_BAD_BLOCK;
               rsp_granted_in = rd_ext[BNO_W-1:0];
               rsp_reload_in  = (count_ff == '0);
            end
         end
         SEL_DUMP_COUNT: begin
            rsp_dump_valid_in = 1'b1;
            rsp_dump_value_in = VAL_W'(count_ff);
            rsp_last_in       = 1'b0;
         end
         SEL_DUMP_ENTRY: begin
            rsp_dump_valid_in = 1'b1;
            rsp_dump_index_in = IDX_W'(ptr_ff) + IDX_W'(1);
            rsp_dump_value_in = rd_ext[VAL_W-1:0];
            rsp_last_in       = (ptr_ff == ADDR_W'(CACHE_ENTRIES - 1));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_granted_ff    <= rsp_granted_in;
         rsp_reload_ff     <= rsp_reload_in;
         rsp_dump_valid_ff <= rsp_dump_valid_in;
         rsp_dump_index_ff <= rsp_dump_index_in;
         rsp_dump_value_ff <= rsp_dump_value_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_reload_needed = rsp_reload_ff;
   assign rsp_dump_valid    = rsp_dump_valid_ff;
   assign rsp_dump_index    = rsp_dump_index_ff;
   assign rsp_dump_value    = rsp_dump_value_ff;
   assign rsp_last          = rsp_last_ff;

   // status to controller
   assign stat.req_kind   = req_type_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff >= COUNT_W'(CACHE_ENTRIES));
   assign stat.free_ok    = free_in_range;
   assign stat.out_free   = out_free;
   assign stat.flush_last = (ptr_ff == ADDR_W'(CACHE_ENTRIES - 1));

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import fbsa_pkg::*;

   // block configuration and run shape
   localparam int CACHE_ENTRIES = 50;
   localparam int BLOCK_BITS    = 24;
   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 60;      // covers a full-cache flush walk
   localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   // request code with no meaning to the block
   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   // load index that selects the count word instead of a cache entry
   localparam logic [IDX_W-1:0] LOAD_COUNT_WORD = 6'd0;

   // one request transaction, field by field
   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic [BNO_W-1:0] block_no;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
   } alloc_req_type;

   // one response transaction, field by field
   typedef struct packed {
      status_type       status;
      logic [BNO_W-1:0] granted;
      logic             reload;
      logic             dump_valid;
      logic [IDX_W-1:0] dump_index;
      logic [VAL_W-1:0] dump_value;
      logic             last;
   } alloc_rsp_type;

   // directed row: optional range change first, then one request;
   // a typed row carries its obvious single answer
   typedef struct {
      bit               set_limits;
      logic [15:0]      start_blk;
      logic [23:0]      total_blk;
      logic [REQ_W-1:0] kind;
      logic [BNO_W-1:0] block_no;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
      bit               typed;
      status_type       want_status;
      logic [BNO_W-1:0] want_block;
      bit               want_reload;
   } directed_row_type;

   // random phase: data area, length, share of frees, idling, hold-off
   typedef struct {
      logic [15:0] start_blk;
      logic [23:0] total_blk;
      int          items;
      int          free_pct;
      bit          idle;
      bit          hold;
   } phase_type;

   // dut inputs, all known from time zero
   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic [REQ_W-1:0] req_type         = '0;
   logic [BNO_W-1:0] req_block_number = '0;
   logic [IDX_W-1:0] req_load_index   = '0;
   logic [VAL_W-1:0] req_load_value   = '0;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;
   logic             rsp_stall        = 1'b0;

   // dut outputs
   logic              req_stall;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [BNO_W-1:0]  rsp_granted_block;
   logic              rsp_reload_needed;
   logic              rsp_dump_valid;
   logic [IDX_W-1:0]  rsp_dump_index;
   logic [VAL_W-1:0]  rsp_dump_value;
   logic              rsp_last;

   // shadow of the free block stack and the range registers
   logic [15:0]              data_start   = 16'd2;
   logic [23:0]              fs_blocks    = 24'd0;
   int                       stack_depth  = 0;
   logic [BLOCK_BITS-1:0]    free_stack [CACHE_ENTRIES];
   bit [CACHE_ENTRIES-1:0]   entry_written = '0;
   bit                       dump_block_pending = 1'b0;

   // answers owed by the block, oldest first
   alloc_rsp_type answers_due [$];

   // run control shared between the sender, receiver and main flow
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_armed  = 1'b0;
   int hold_left   = 0;
   int failure_count = 0;
   int cycle_count   = 0;

   // directed part: reset range first, then a narrow data area
   directed_row_type directed_rows [24] = '{
      // reset range: nothing is inside the data area
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,      1, ST_NO_SPACE, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_FREE,    24'd5,      6'd0,  24'd0,      1, ST_FREE_IGNORED, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_UNKNOWN, 24'hFFFFFF, 6'd63, 24'hFFFFFF, 1, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      LOAD_COUNT_WORD, 24'hFFFFFF,
        1, ST_COUNT_CLAMPED, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      LOAD_COUNT_WORD, 24'd0, 1, ST_OK, 0, 0},
      // data area 16 .. 0xfff, range edges on free
      '{1, 16'd16, 24'h1000,  REQ_FREE,    24'd15,     6'd0,  24'd0,      1, ST_FREE_IGNORED, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_FREE,    24'h1000,   6'd0,  24'd0,      1, ST_FREE_IGNORED, 0, 0},
      // first free into an empty stack puts the zero sentinel underneath
      '{0, 16'd0,  24'd0,     REQ_FREE,    24'd16,     6'd0,  24'd0,      1, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_FREE,    24'hFFF,    6'd0,  24'd0,      1, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,      1, ST_OK, 24'hFFF, 0},
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,      1, ST_OK, 24'd16, 0},
      // popping the sentinel: count drops, still no space
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,      1, ST_NO_SPACE, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,      1, ST_NO_SPACE, 0, 0},
      // entry loads at both ends and beyond the cache
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      6'd1,  24'h800,    0, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'hFFFFFF, 6'd50, 24'hFFFFFF, 0, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      6'd51, 24'd7,      1, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      6'd63, 24'd0,      1, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      LOAD_COUNT_WORD, 24'd1, 0, ST_OK, 0, 0},
      // last entry popped: a dump block
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,      1, ST_OK, 24'h800, 1},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      LOAD_COUNT_WORD, 24'd51,
        1, ST_COUNT_CLAMPED, 0, 0},
      // popped block above the data area
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,
        1, ST_BAD_BLOCK, 24'hFFFFFF, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      LOAD_COUNT_WORD, 24'd1, 0, ST_OK, 0, 0},
      '{0, 16'd0,  24'd0,     REQ_LOAD,    24'd0,      6'd1,  24'd5,      0, ST_OK, 0, 0},
      // popped block below the data area, stack now empty
      '{0, 16'd0,  24'd0,     REQ_ALLOC,   24'd0,      6'd0,  24'd0,      1, ST_BAD_BLOCK, 24'd5, 1}
   };

   // random phases: range extremes, a long stretch with no idling,
   // and one receiver hold-off
   phase_type phases [5] = '{
      '{16'd2,     24'h000400, 70, 60, 1'b1, 1'b0},
      '{16'd0,     24'hFFFFFF, 70, 50, 1'b1, 1'b1},
      '{16'hFFFF,  24'h01FFFF, 60, 62, 1'b0, 1'b0},
      '{16'h0100,  24'h000180, 60, 35, 1'b1, 1'b0},
      '{16'hFFFF,  24'hFFFFFF, 70, 55, 1'b1, 1'b0}
   };

   free_block_stack_allocator_top #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .BLOCK_BITS    (BLOCK_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_block_number  (req_block_number),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_block (rsp_granted_block),
      .rsp_reload_needed (rsp_reload_needed),
      .rsp_dump_valid    (rsp_dump_valid),
      .rsp_dump_index    (rsp_dump_index),
      .rsp_dump_value    (rsp_dump_value),
      .rsp_last          (rsp_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
   end

   // block number test against the shadow range registers
   function automatic bit in_data_area(input logic [23:0] blk);
      return ({8'd0, data_start} <= blk) && (blk < fs_blocks);
   endfunction

   // a block number inside the data area, edges now and then
   function automatic logic [23:0] block_in_area();
      int roll;
      int span;
      roll = $urandom_range(0, 99);
      span = int'(fs_blocks) - int'(data_start);
      if (span <= 0) return {8'd0, data_start};
      if (roll < 10) return {8'd0, data_start};
      if (roll < 20) return fs_blocks - 24'd1;
      return 24'(int'(data_start) + int'($urandom % span));
   endfunction

   // shadow of the block: applies one accepted request transaction to the
   // free block stack and queues every response it owes
   task automatic free_stack_step(input alloc_req_type rq, output bit no_effect);
      alloc_rsp_type ans;
      logic [BLOCK_BITS-1:0] top;
      ans = '0;
      ans.status = ST_OK;
      ans.last = 1'b1;
      no_effect = 1'b0;
      case (rq.kind)
         REQ_ALLOC: begin
            if (stack_depth == 0) begin
               ans.status = ST_NO_SPACE;
            end else begin
               stack_depth--;
               top = free_stack[stack_depth];
               if (top == '0) begin
                  // zero sentinel: the chain is exhausted
                  ans.status = ST_NO_SPACE;
               end else begin
                  ans.granted = top;
                  ans.reload = (stack_depth == 0);
                  ans.status = in_data_area(top) ? ST_OK : ST_BAD_BLOCK;
                  if (ans.reload) dump_block_pending = 1'b1;
               end
            end
            answers_due.push_back(ans);
         end
         REQ_FREE: begin
            if (!in_data_area(rq.block_no)) begin
               ans.status = ST_FREE_IGNORED;
               no_effect = 1'b1;
               answers_due.push_back(ans);
            end else begin
               if (stack_depth == 0) begin
                  free_stack[0] = '0;
                  entry_written[0] = 1'b1;
                  stack_depth = 1;
               end
               if (stack_depth >= CACHE_ENTRIES) begin
                  // full stack: count word, then every entry, into the freed block
                  ans.dump_valid = 1'b1;
                  ans.last = 1'b0;
                  ans.dump_index = LOAD_COUNT_WORD;
                  ans.dump_value = VAL_W'(stack_depth);
                  answers_due.push_back(ans);
                  for (int k = 0; k < CACHE_ENTRIES; k++) begin
                     ans.dump_index = IDX_W'(k + 1);
                     ans.dump_value = free_stack[k];
                     ans.last = (k == CACHE_ENTRIES - 1);
                     answers_due.push_back(ans);
                  end
                  stack_depth = 0;
               end else begin
                  answers_due.push_back(ans);
               end
               free_stack[stack_depth] = rq.block_no;
               entry_written[stack_depth] = 1'b1;
               stack_depth++;
            end
         end
         REQ_LOAD: begin
            if (rq.index == LOAD_COUNT_WORD) begin
               if (rq.value > CACHE_ENTRIES) begin
                  stack_depth = CACHE_ENTRIES;
                  ans.status = ST_COUNT_CLAMPED;
               end else begin
                  stack_depth = int'(rq.value);
               end
            end else if (rq.index <= CACHE_ENTRIES) begin
               free_stack[rq.index - 1] = rq.value;
               entry_written[rq.index - 1] = 1'b1;
            end else begin
               no_effect = 1'b1;
            end
            answers_due.push_back(ans);
         end
         default: begin
            no_effect = 1'b1;
            answers_due.push_back(ans);
         end
      endcase
   endtask

   // sender: optional idle gap, then offer until the transaction is taken
   task automatic offer_request(input alloc_req_type rq, output bit no_effect);
      int gap;
      if (req_idle_on && $urandom_range(0, 99) < 30) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= rq.kind;
      req_block_number <= rq.block_no;
      req_load_index   <= rq.index;
      req_load_value   <= rq.value;
      do @(posedge clock); while (req_stall);
      free_stack_step(rq, no_effect);
   endtask

   // stop offering, wait for every owed response, let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both range registers, back to back, only while the block is idle
   task automatic set_limits(input logic [15:0] start_blk, input logic [23:0] total_blk);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DATA_START;
      csr_write_data   <= {8'd0, start_blk};
      @(posedge clock);
      csr_index        <= CSR_TOTAL_BLOCKS;
      csr_write_data   <= total_blk;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      data_start = start_blk;
      fs_blocks  = total_blk;
   endtask

   task automatic run_directed();
      directed_row_type row;
      alloc_req_type    rq;
      bit               no_effect;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.set_limits) begin
            settle();
            set_limits(row.start_blk, row.total_blk);
         end
         rq = '{row.kind, row.block_no, row.index, row.value};
         offer_request(rq, no_effect);
         // obvious rows: the typed answer stands in for the shadow's
         if (row.typed) begin
            void'(answers_due.pop_back());
            answers_due.push_back('{row.want_status, row.want_block, row.want_reload,
                                    1'b0, '0, '0, 1'b1});
         end
      end
      settle();
   endtask

   task automatic run_phase(input phase_type ph);
      alloc_req_type rq;
      alloc_req_type refill [$];
      bit            no_effect;
      bit            hold_done;
      int            counted;
      int            roll;
      int            words;
      int            alloc_pct;
      logic [23:0]   pick;
      req_idle_on = ph.idle;
      rsp_idle_on = ph.idle;
      set_limits(ph.start_blk, ph.total_blk);
      counted   = 0;
      hold_done = 1'b0;
      alloc_pct = 88 - ph.free_pct;
      while (counted < ph.items) begin
         // a dump block was handed out: mostly feed back its count word and
         // entries, as the caller reading the chained block would
         if (refill.size() == 0 && dump_block_pending) begin
            dump_block_pending = 1'b0;
            if ($urandom_range(0, 99) < 85) begin
               roll = $urandom_range(0, 99);
               if (roll < 70) words = $urandom_range(1, 6);
               else if (roll < 85) words = CACHE_ENTRIES;
               else if (roll < 95) words = $urandom_range(7, CACHE_ENTRIES - 1);
               else words = $urandom_range(CACHE_ENTRIES + 1, 63);
               refill.push_back('{REQ_LOAD, 24'($urandom), LOAD_COUNT_WORD, 24'(words)});
               for (int k = 1; k <= words && k <= CACHE_ENTRIES; k++) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 85) pick = block_in_area();
                  else if (roll < 93) pick = '0;
                  else pick = 24'($urandom);
                  refill.push_back('{REQ_LOAD, 24'($urandom), IDX_W'(k), pick});
               end
            end
         end
         if (refill.size() != 0) begin
            rq = refill.pop_front();
         end else begin
            roll = $urandom_range(0, 99);
            rq = '{REQ_ALLOC, 24'($urandom), IDX_W'($urandom), 24'($urandom)};
            if (roll < ph.free_pct) begin
               rq.kind = REQ_FREE;
               rq.block_no = block_in_area();
            end else if (roll < ph.free_pct + alloc_pct) begin
               rq.kind = REQ_ALLOC;
            end else if (roll < 91) begin
               // count word: small values or any 24-bit value (clamps)
               rq.kind = REQ_LOAD;
               rq.index = LOAD_COUNT_WORD;
               if ($urandom_range(0, 1) != 0) rq.value = 24'($urandom_range(0, 63));
            end else if (roll < 94) begin
               rq.kind = REQ_FREE;     // any number, mostly outside the area
            end else if (roll < 97) begin
               rq.kind = REQ_LOAD;
               rq.index = IDX_W'($urandom_range(1, 63));
            end else begin
               rq.kind = REQ_UNKNOWN;
            end
            // never pop or flush a stack entry that was never written:
            // load that entry instead
            if (rq.kind == REQ_ALLOC && stack_depth != 0 &&
                !entry_written[stack_depth - 1]) begin
               rq.kind  = REQ_LOAD;
               rq.index = IDX_W'(stack_depth);
               rq.value = block_in_area();
            end else if (rq.kind == REQ_FREE && in_data_area(rq.block_no) &&
                         stack_depth >= CACHE_ENTRIES && !(&entry_written)) begin
               for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
                  if (!entry_written[k]) begin
                     rq.kind  = REQ_LOAD;
                     rq.index = IDX_W'(k + 1);
                     rq.value = block_in_area();
                  end
               end
            end
         end
         offer_request(rq, no_effect);
         if (!no_effect) counted++;
         // one long receiver hold-off while the sender keeps offering
         if (ph.hold && !hold_done && counted >= 12) begin
            hold_armed = 1'b1;
            hold_done  = 1'b1;
         end
      end
      settle();
   endtask

   // receiver: random stalls, or a counted hold-off when armed
   always @(posedge clock) begin
      if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_idle_on && ($urandom_range(0, 99) < 25);
      end
   end

   task automatic report_mismatch(input string what, input alloc_rsp_type want,
                                  input alloc_rsp_type seen);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) begin
         $display("%s at cycle %0d (expected / actual):", what, cycle_count);
         $display("  status %0d / %0d  granted %h / %h  reload %0b / %0b",
                  want.status, seen.status, want.granted, seen.granted,
                  want.reload, seen.reload);
         $display("  dump %0b / %0b  index %0d / %0d  value %h / %h  last %0b / %0b",
                  want.dump_valid, seen.dump_valid, want.dump_index, seen.dump_index,
                  want.dump_value, seen.dump_value, want.last, seen.last);
      end
   endtask

   // response monitor: each accepted response transaction against the oldest owed
   always @(posedge clock) begin
      alloc_rsp_type seen;
      alloc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{status_type'(rsp_status), rsp_granted_block, rsp_reload_needed,
                  rsp_dump_valid, rsp_dump_index, rsp_dump_value, rsp_last};
         if (answers_due.size() == 0) begin
            report_mismatch("response with nothing owed", '0, seen);
         end else begin
            want = answers_due.pop_front();
            if (seen !== want) report_mismatch("response mismatch", want, seen);
         end
      end
   end

   // run time guard
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
   end

   // main flow: reset once, directed rows, random phases, verdict
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      foreach (phases[p]) run_phase(phases[p]);
      if (answers_due.size() != 0) begin
         $display("%0d owed responses never arrived", answers_due.size());
         failure_count++;
      end
      if (failure_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
